FILE: rtl/core/ckerng_pkg.sv
// ----------------------------------------------------------------------------
// ckerng_pkg
// Shared types, constants and helper functions for the ChaCha20 random
// byte generator.
// ----------------------------------------------------------------------------
package ckerng_pkg;

  localparam int unsigned POOL_BYTES_DEF = 1024;
  localparam int unsigned KEY_BYTES      = 32;
  localparam int unsigned MAX_REQ        = 64;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned SEED_W         = 64;
  localparam int unsigned NUM_ROUNDS     = 20;

  // Seed register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEED0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED3 = 2'd3;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_CHECK,
    ST_KEYRD,
    ST_KEYLD,
    ST_INIT,
    ST_ROUND,
    ST_WRITE,
    ST_RDREQ,
    ST_RDWAIT,
    ST_SEND
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic seed_wr;      // write seed byte at seed index
    logic seed_clr;     // clear seed byte index
    logic key_rd;       // issue pool read for key byte at key index
    logic key_cap;      // capture returned key byte
    logic blk_init;     // load ChaCha state for the current block
    logic round_step;   // run one column or diagonal round
    logic out_wr;       // write one keystream byte to the pool
    logic refill_start; // clear block counter and offsets
    logic pos_key;      // set read position to KEY_BYTES
    logic pos_top;      // set read position to pool size
    logic byte_rd;      // issue pool read at read position
    logic byte_adv;     // advance read position
    logic req_load;     // latch request count
    logic out_load;     // latch output byte and last flag
  } ckerng_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seed_done;
    logic key_done;
    logic rounds_done;
    logic blk_done;
    logic pool_done;
    logic pool_empty;
    logic req_zero;
    logic req_last;
  } ckerng_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    rotl32 = (v << s) | (v >> (32 - s));
  endfunction

endpackage

FILE: rtl/core/ckerng_if.sv
// ----------------------------------------------------------------------------
// ckerng_if
// Valid/ready channel carrying a payload of generic type.
// ----------------------------------------------------------------------------
interface ckerng_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/chacha20_key_erasure_rng.sv
// ----------------------------------------------------------------------------
// chacha20_key_erasure_rng
// ChaCha20 fast-key-erasure random byte generator, top level.
// ----------------------------------------------------------------------------
// Each request word asks for 0 to 127 bytes, clamped to 64; the block sends them
// one word per byte, flagging the final one. Each byte goes through a pool check,
// a pool read through the single-port pool RAM, a read wait, then hand-off; the
// read waits while the previous byte is still held on the output. The first request
// after reset also copies the seed key into the pool. When the pool runs out, a
// refill rewrites it: it reads the key, then per 64-byte block runs a setup step,
// the rounds and the byte writes.
module chacha20_key_erasure_rng
  import ckerng_pkg::*;
#(
  parameter int unsigned POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ckerng_if.sink   in_ch,
  ckerng_if.source out_ch,
  ckerng_if.sink   cfg_ch
);

  ckerng_cmd_t cmd;
  ckerng_sts_t sts;
  logic [7:0]  byte_w;
  logic        last_w;
  logic [CNT_W-1:0]     req_w;
  logic [CFG_IDX_W-1:0] cfg_idx_w;
  logic [SEED_W-1:0]    cfg_data_w;

  // Unpack the channel payloads.
  assign req_w      = in_ch.data.byte_count;
  assign cfg_idx_w  = cfg_ch.data.index;
  assign cfg_data_w = cfg_ch.data.value;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.data.out_byte = byte_w;
  assign out_ch.data.last     = last_w;

  ckerng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ckerng_dp #(.POOL_BYTES(POOL_BYTES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_idx_w),
    .cfg_data  (cfg_data_w),
    .req_count (req_w),
    .byte_o    (byte_w),
    .last_o    (last_w)
  );

endmodule

FILE: rtl/core/ckerng_ram.sv
// ----------------------------------------------------------------------------
// ckerng_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ckerng_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/ckerng_dp.sv
// ----------------------------------------------------------------------------
// ckerng_dp
// Datapath: seed registers, pool memory, ChaCha20 round unit and pointers.
// ----------------------------------------------------------------------------
module ckerng_dp
  import ckerng_pkg::*;
#(
  parameter int unsigned POOL_BYTES = POOL_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ckerng_cmd_t          cmd,
  output ckerng_sts_t          sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SEED_W-1:0]    cfg_data,
  input  logic [CNT_W-1:0]     req_count,
  output logic [7:0]           byte_o,
  output logic                 last_o
);

  localparam int unsigned AW    = $clog2(POOL_BYTES);
  localparam int unsigned PW    = $clog2(POOL_BYTES + 1);
  localparam int unsigned NBLK  = (POOL_BYTES + 63) / 64;
  localparam int unsigned BW    = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int unsigned KBW   = $clog2(KEY_BYTES);
  localparam int unsigned WFW   = BW + 6;

  // Seed registers.
  logic [SEED_W-1:0] seed_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        seed_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SEED0: seed_r[0] <= cfg_data;
        REG_SEED1: seed_r[1] <= cfg_data;
        REG_SEED2: seed_r[2] <= cfg_data;
        REG_SEED3: seed_r[3] <= cfg_data;
        default:   seed_r[0] <= seed_r[0];
      endcase
    end
  end

  // Key byte index shared by seeding and key loading.
  logic [KBW:0] kidx_r;
  logic [KBW:0] kcap_r;
  logic [31:0]  key_r [8];

  // ChaCha working and initial state.
  logic [31:0] x_r [16];
  logic [31:0] xi_r [16];
  logic [4:0]  rnd_r;
  logic [5:0]  boff_r;
  logic [BW-1:0] blk_r;
  logic [PW-1:0] pos_r;
  logic [CNT_W-1:0] rem_r;

  // Pool memory address and data selection.
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;
  logic [31:0]    ks_word;
  logic [WFW-1:0] wr_full;

  assign ks_word = x_r[boff_r[5:2]] + xi_r[boff_r[5:2]];
  assign wr_full = {blk_r, boff_r};

  always_comb begin
    ram_we    = cmd.seed_wr | cmd.out_wr;
    ram_addr  = pos_r[AW-1:0];
    ram_wdata = ks_word[8*boff_r[1:0] +: 8];
    if (cmd.seed_wr) begin
      ram_addr  = AW'(kidx_r[KBW-1:0]);
      ram_wdata = seed_r[kidx_r[KBW-1:3]][8*kidx_r[2:0] +: 8];
    end else if (cmd.out_wr) begin
      ram_addr  = wr_full[AW-1:0];
    end else if (cmd.key_rd) begin
      ram_addr  = AW'(kidx_r[KBW-1:0]);
    end
  end

  ckerng_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // One round: four quarter rounds in parallel, column or diagonal.
  function automatic void qr(inout logic [31:0] a, inout logic [31:0] b,
                             inout logic [31:0] c, inout logic [31:0] d);
    a = a + b; d = rotl32(d ^ a, 16);
    c = c + d; b = rotl32(b ^ c, 12);
    a = a + b; d = rotl32(d ^ a, 8);
    c = c + d; b = rotl32(b ^ c, 7);
  endfunction

  logic [31:0] y [16];
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      y[i] = x_r[i];
    end
    if (!rnd_r[0]) begin
      qr(y[0], y[4], y[8],  y[12]);
      qr(y[1], y[5], y[9],  y[13]);
      qr(y[2], y[6], y[10], y[14]);
      qr(y[3], y[7], y[11], y[15]);
    end else begin
      qr(y[0], y[5], y[10], y[15]);
      qr(y[1], y[6], y[11], y[12]);
      qr(y[2], y[7], y[8],  y[13]);
      qr(y[3], y[4], y[9],  y[14]);
    end
  end

  // Sequencing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kidx_r <= '0;
      kcap_r <= '0;
      rnd_r  <= '0;
      boff_r <= '0;
      blk_r  <= '0;
      pos_r  <= '0;
      rem_r  <= '0;
    end else begin
      if (cmd.seed_clr) begin
        kidx_r <= '0;
        kcap_r <= '0;
      end else if (cmd.seed_wr || cmd.key_rd) begin
        kidx_r <= kidx_r + 1'b1;
      end
      if (cmd.key_cap) begin
        kcap_r <= kcap_r + 1'b1;
      end
      if (cmd.refill_start) begin
        blk_r  <= '0;
        boff_r <= '0;
      end
      if (cmd.blk_init) begin
        rnd_r  <= '0;
        boff_r <= '0;
      end else if (cmd.round_step) begin
        rnd_r <= rnd_r + 1'b1;
      end
      if (cmd.out_wr) begin
        boff_r <= boff_r + 1'b1;
        if (boff_r == 6'd63 || wr_full == WFW'(POOL_BYTES - 1)) begin
          blk_r <= blk_r + 1'b1;
        end
      end
      if (cmd.pos_key) begin
        pos_r <= PW'(KEY_BYTES);
      end else if (cmd.pos_top) begin
        pos_r <= PW'(POOL_BYTES);
      end else if (cmd.byte_adv) begin
        pos_r <= pos_r + 1'b1;
      end
      if (cmd.req_load) begin
        rem_r <= (req_count > CNT_W'(MAX_REQ)) ? CNT_W'(MAX_REQ) : req_count;
      end else if (cmd.byte_adv) begin
        rem_r <= rem_r - 1'b1;
      end
    end
  end

  // Key capture and ChaCha state.
  always_ff @(posedge clk) begin
    if (cmd.key_cap) begin
      key_r[kcap_r[KBW-1:2]][8*kcap_r[1:0] +: 8] <= ram_rdata;
    end
    if (cmd.blk_init) begin
      xi_r[0]  <= SIGMA0;
      xi_r[1]  <= SIGMA1;
      xi_r[2]  <= SIGMA2;
      xi_r[3]  <= SIGMA3;
      x_r[0]   <= SIGMA0;
      x_r[1]   <= SIGMA1;
      x_r[2]   <= SIGMA2;
      x_r[3]   <= SIGMA3;
      for (int i = 0; i < 8; i++) begin
        xi_r[4+i] <= key_r[i];
        x_r[4+i]  <= key_r[i];
      end
      xi_r[12] <= 32'(blk_r);
      x_r[12]  <= 32'(blk_r);
      for (int i = 13; i < 16; i++) begin
        xi_r[i] <= '0;
        x_r[i]  <= '0;
      end
    end else if (cmd.round_step) begin
      for (int i = 0; i < 16; i++) begin
        x_r[i] <= y[i];
      end
    end
    if (cmd.out_load) begin
      byte_o <= ram_rdata;
      last_o <= (rem_r == CNT_W'(1));
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.seed_done   = (kidx_r == (KBW+1)'(KEY_BYTES - 1));
    sts.key_done    = (kcap_r == (KBW+1)'(KEY_BYTES - 1));
    sts.rounds_done = (rnd_r == 5'(NUM_ROUNDS - 1));
    sts.blk_done    = (boff_r == 6'd63) || (wr_full == WFW'(POOL_BYTES - 1));
    sts.pool_done   = (wr_full == WFW'(POOL_BYTES - 1));
    sts.pool_empty  = (pos_r >= PW'(POOL_BYTES));
    sts.req_zero    = (rem_r == '0);
    sts.req_last    = (rem_r == CNT_W'(1));
  end

endmodule

FILE: rtl/core/ckerng_ctrl.sv
// ----------------------------------------------------------------------------
// ckerng_ctrl
// Controller: sequences seeding, pool refills and byte delivery.
// ----------------------------------------------------------------------------
module ckerng_ctrl
  import ckerng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output ckerng_cmd_t cmd,
  input  ckerng_sts_t sts
);

  ctrl_state_t state_r, state_nxt;
  logic        seeded_r, seeded_nxt;
  logic        oval_r, oval_nxt;

  assign out_valid = oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      seeded_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
      oval_r   <= oval_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    seeded_nxt = seeded_r;
    oval_nxt   = oval_r;
    cmd        = '0;
    in_ready   = 1'b0;
    if (oval_r && out_ready) begin
      oval_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          cmd.seed_clr = 1'b1;
          state_nxt = seeded_r ? ST_CHECK : ST_SEED;
        end
      end
      ST_SEED: begin
        cmd.seed_wr = 1'b1;
        if (sts.seed_done) begin
          cmd.pos_top = 1'b1;
          seeded_nxt  = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.req_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.pool_empty) begin
          cmd.seed_clr     = 1'b1;
          cmd.refill_start = 1'b1;
          state_nxt        = ST_KEYRD;
        end else begin
          state_nxt = ST_RDREQ;
        end
      end
      ST_KEYRD: begin
        cmd.key_rd = 1'b1;
        state_nxt  = ST_KEYLD;
      end
      ST_KEYLD: begin
        cmd.key_cap = 1'b1;
        if (sts.key_done) begin
          state_nxt = ST_INIT;
        end else begin
          state_nxt = ST_KEYRD;
        end
      end
      // Block setup once the key is complete and the block counter is current.
      ST_INIT: begin
        cmd.blk_init = 1'b1;
        state_nxt    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (sts.rounds_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.out_wr = 1'b1;
        if (sts.pool_done) begin
          cmd.pos_key = 1'b1;
          state_nxt   = ST_RDREQ;
        end else if (sts.blk_done) begin
          state_nxt = ST_INIT;
        end
      end
      ST_RDREQ: begin
        if (!oval_r || out_ready) begin
          cmd.byte_rd = 1'b1;
          state_nxt   = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        cmd.out_load = 1'b1;
        cmd.byte_adv = 1'b1;
        oval_nxt     = 1'b1;
        state_nxt    = sts.req_last ? ST_IDLE : ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: verif/tb_chacha20_key_erasure_rng.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chacha20_key_erasure_rng
// Self-checking bench for the ChaCha20 fast-key-erasure byte generator.
// ----------------------------------------------------------------------------
// Requests are driven from a queue and each accepted request is run through a
// local model of the seed, pool and refill logic. The bytes it predicts are
// compared word by word with what the block sends. The run moves through
// several idling phases. It also holds the receiver off long enough to back
// the block up, and drains fully between phases.
// ----------------------------------------------------------------------------
module tb_chacha20_key_erasure_rng;
  import ckerng_pkg::*;

  localparam int unsigned POOL_N     = 1024;
  localparam int unsigned WDOG_LIMIT = 60000;

  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
  } req_word_t;
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } rng_word_t;
  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SEED_W-1:0]    value;
  } seed_wr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ckerng_if #(.payload_t(req_word_t)) in_ch ();
  ckerng_if #(.payload_t(rng_word_t)) out_ch ();
  ckerng_if #(.payload_t(seed_wr_t))  cfg_ch ();

  chacha20_key_erasure_rng #(.POOL_BYTES(POOL_N)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  // Generator model state.
  logic [SEED_W-1:0] seed_regs [4];
  logic [7:0]        pool [POOL_N];
  int unsigned       rd_pos;
  bit                seeded;
  logic [31:0]       ks_x [16];

  req_word_t   pending_reqs [$];
  rng_word_t   expected_bytes [$];
  int unsigned errors = 0;
  int unsigned idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  bit          rx_long_hold = 1'b0;
  int unsigned wdog = 0;

  // One ChaCha quarter round on the working state.
  task automatic qr(input int a, input int b, input int c, input int d);
    ks_x[a] = ks_x[a] + ks_x[b]; ks_x[d] = ks_x[d] ^ ks_x[a];
    ks_x[d] = {ks_x[d][15:0], ks_x[d][31:16]};
    ks_x[c] = ks_x[c] + ks_x[d]; ks_x[b] = ks_x[b] ^ ks_x[c];
    ks_x[b] = {ks_x[b][19:0], ks_x[b][31:20]};
    ks_x[a] = ks_x[a] + ks_x[b]; ks_x[d] = ks_x[d] ^ ks_x[a];
    ks_x[d] = {ks_x[d][23:0], ks_x[d][31:24]};
    ks_x[c] = ks_x[c] + ks_x[d]; ks_x[b] = ks_x[b] ^ ks_x[c];
    ks_x[b] = {ks_x[b][24:0], ks_x[b][31:25]};
  endtask

  // Rewrite the whole pool with keystream keyed by its first 32 bytes.
  task automatic refill_pool();
    logic [31:0] key [8];
    logic [31:0] init [16];
    logic [31:0] w;
    int unsigned off;
    int unsigned ctr;
    for (int i = 0; i < 8; i++)
      key[i] = {pool[4*i+3], pool[4*i+2], pool[4*i+1], pool[4*i]};
    off = 0;
    ctr = 0;
    while (off < POOL_N) begin
      init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
      for (int i = 0; i < 8; i++) init[4+i] = key[i];
      init[12] = ctr; init[13] = '0; init[14] = '0; init[15] = '0;
      for (int i = 0; i < 16; i++) ks_x[i] = init[i];
      for (int r = 0; r < NUM_ROUNDS / 2; r++) begin
        qr(0, 4, 8, 12); qr(1, 5, 9, 13); qr(2, 6, 10, 14); qr(3, 7, 11, 15);
        qr(0, 5, 10, 15); qr(1, 6, 11, 12); qr(2, 7, 8, 13); qr(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        w = ks_x[i] + init[i];
        for (int b = 0; b < 4; b++)
          if (off + 4*i + b < POOL_N) pool[off + 4*i + b] = w[8*b +: 8];
      end
      off += 64;
      ctr++;
    end
    rd_pos = KEY_BYTES;
  endtask

  // Work out the bytes one request produces and queue them.
  task automatic predict_request(input req_word_t req);
    int unsigned n;
    rng_word_t   wd;
    n = (req.byte_count > MAX_REQ) ? MAX_REQ : req.byte_count;
    if (!seeded) begin
      for (int i = 0; i < KEY_BYTES; i++)
        pool[i] = seed_regs[i / 8][8*(i % 8) +: 8];
      rd_pos = POOL_N;
      seeded = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      if (rd_pos >= POOL_N) refill_pool();
      wd.out_byte = pool[rd_pos];
      wd.last     = (k + 1 == n);
      expected_bytes.push_back(wd);
      rd_pos++;
    end
  endtask

  // Request driver: keeps valid up until the word is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_request(in_ch.data);
        void'(pending_reqs.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 &&
            !((idle_mode == 1 && $urandom_range(99) < 60) ||
              (idle_mode == 3 && $urandom_range(99) < 30))) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_reqs[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Byte monitor: random stalls and check against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected word: out_byte %0h last %0b",
                 out_ch.data.out_byte, out_ch.data.last);
          errors++;
        end else begin
          if (out_ch.data.out_byte !== expected_bytes[0].out_byte) begin
            $error("out_byte: expected %0h actual %0h",
                   expected_bytes[0].out_byte, out_ch.data.out_byte);
            errors++;
          end
          if (out_ch.data.last !== expected_bytes[0].last) begin
            $error("last: expected %0b actual %0b",
                   expected_bytes[0].last, out_ch.data.last);
            errors++;
          end
          void'(expected_bytes.pop_front());
        end
      end
      out_ch.ready <= !rx_long_hold &&
                      !((idle_mode == 2 && $urandom_range(99) < 60) ||
                        (idle_mode == 3 && $urandom_range(99) < 30));
    end
  end

  // Watchdog on cycles with no word moving on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("FAIL chacha20_key_erasure_rng");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  // Write one seed register; the model copies it once the word is taken, unless already seeded.
  task automatic write_seed(input logic [CFG_IDX_W-1:0] idx,
                            input logic [SEED_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (!seeded) seed_regs[idx] = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic req_word_t rand_req();
    int unsigned r;
    req_word_t   q;
    r = $urandom_range(99);
    if (r < 8) q.byte_count = CNT_W'($urandom_range(127, 65));
    else if (r < 14) q.byte_count = '0;
    else q.byte_count = CNT_W'($urandom_range(64, 1));
    return q;
  endfunction

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    for (int i = 0; i < 4; i++) seed_regs[i] = '0;
    for (int i = 0; i < POOL_N; i++) pool[i] = '0;
    rd_pos = 0;
    seeded = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Seed key with extreme and mixed patterns before the first request.
    write_seed(REG_SEED0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_seed(REG_SEED1, 64'h0000_0000_0000_0000);
    write_seed(REG_SEED2, {$urandom(), $urandom()});
    write_seed(REG_SEED3, 64'h8000_0000_0000_0001);

    // Directed: empty first request seeds, then every count bit and the
    // saturating sizes.
    pending_reqs.push_back(7'd0);
    pending_reqs.push_back(7'd64);
    pending_reqs.push_back(7'd1);
    pending_reqs.push_back(7'd127);
    pending_reqs.push_back(7'd65);
    pending_reqs.push_back(7'd0);
    for (int b = 0; b < CNT_W; b++) pending_reqs.push_back(req_word_t'(CNT_W'(1 << b)));
    pending_reqs.push_back(7'd63);
    pending_reqs.push_back(7'd100);
    drain();

    // Late seed writes must leave the stream untouched.
    write_seed(REG_SEED0, 64'h0);
    write_seed(REG_SEED1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_seed(REG_SEED2, 64'h0);
    write_seed(REG_SEED3, 64'hFFFF_FFFF_FFFF_FFFF);

    // Random phases, one per idling mode, draining between them.
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      for (int i = 0; i < 30; i++) pending_reqs.push_back(rand_req());
      drain();
    end

    // Receiver held off while the sender keeps offering requests.
    idle_mode = 0;
    rx_long_hold = 1'b1;
    for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req());
    repeat (3000) @(posedge clk);
    rx_long_hold = 1'b0;
    drain();

    if (errors == 0) begin
      $display("PASS chacha20_key_erasure_rng");
    end else begin
      $display("FAIL chacha20_key_erasure_rng");
    end
    $finish;
  end

endmodule
